/* src/fbba_pkg.sv */
// Shared types, constants and helpers for the frame bump buffer allocator.
// No dependencies; every other file in src imports this package.
package fbba_pkg;

    localparam int POOL_BUFFERS = 16;
    localparam int ID_W         = $clog2(POOL_BUFFERS);
    localparam int CNT_W        = ID_W + 1;
    localparam int SIZE_W       = 25;
    localparam int ALIGN_W      = 4;
    localparam int FIF_W        = 5;
    localparam int FRAME_W      = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = SIZE_W;
    localparam int STATUS_W     = 2;
    localparam int RND_W        = SIZE_W + 2;

    localparam logic [SIZE_W-1:0]  FILL_MAX          = '1;
    localparam logic [SIZE_W-1:0]  BACKING_SIZE_RST  = SIZE_W'(65536);
    localparam logic [ALIGN_W-1:0] ALIGN_LOG2_RST    = ALIGN_W'(8);
    localparam logic [FIF_W-1:0]   FIF_RST           = FIF_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BACKING_SIZE     = 2'd0,
        CFG_ALIGN_LOG2       = 2'd1,
        CFG_FRAMES_IN_FLIGHT = 2'd2
    } cfg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERSIZE  = 2'd1,
        STATUS_EXHAUSTED = 2'd2
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;        // latch the size of an allocate request
        logic start_frame;     // bump the frame counter, clear the freed tally
        logic exec_alloc;      // commit an allocation and load its response
        logic walk_sel;        // point the queue read port at the oldest entry
        logic pop;             // retire the oldest in-use buffer
        logic load_frame_rsp;  // load the next-frame response
    } fbba_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic can_pop;
    } fbba_stat_t;

    // Round up to the alignment, saturate at the largest fill offset.
    function automatic logic [SIZE_W-1:0] round_fill(
        input logic [SIZE_W:0]    v,
        input logic [ALIGN_W-1:0] al
    );
        logic [RND_W-1:0] mask;
        logic [RND_W-1:0] r;
        mask = (RND_W'(1) << al) - RND_W'(1);
        r    = ({1'b0, v} + mask) & ~mask;
        return (r > RND_W'(FILL_MAX)) ? FILL_MAX : r[SIZE_W-1:0];
    endfunction

endpackage

/* src/fbba_if.sv */
// Handshake channels of the allocator: request, response and register write.
// Depends on fbba_pkg for field widths.
interface fbba_req_if
    import fbba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [SIZE_W-1:0] size;

    modport source (output valid, output command, output size, input ready);
    modport sink   (input valid, input command, input size, output ready);
endinterface

interface fbba_rsp_if
    import fbba_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     buffer_id;
    logic [SIZE_W-1:0]   offset;
    logic                fresh_buffer;
    logic [CNT_W-1:0]    retired_count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output buffer_id, output offset, output fresh_buffer,
                    output retired_count, output status, input ready);
    modport sink   (input valid, input buffer_id, input offset, input fresh_buffer,
                    input retired_count, input status, output ready);
endinterface

interface fbba_cfg_if
    import fbba_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/fbba_ctrl.sv */
// Sequencing state machine: request handshake, retirement walk, response valid.
// Depends on fbba_pkg for the command and status structs.
module fbba_ctrl
    import fbba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_command,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  fbba_stat_t stat,
    output fbba_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_command)
                    begin
                        cmd.start_frame = 1'b1;
                        state_next      = ST_WALK;
                    end
                    else
                    begin
                        cmd.load_req = 1'b1;
                        state_next   = ST_ALLOC;
                    end
                end
            end
            ST_ALLOC:
            begin
                // hold until the response register can take the result
                if (out_free)
                begin
                    cmd.exec_alloc = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                cmd.walk_sel = 1'b1;
                if (stat.can_pop)
                begin
                    cmd.pop = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.load_frame_rsp = 1'b1;
                    rsp_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_alloc_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC && out_free) |=> (state_reg == ST_IDLE && rsp_valid_reg))
        else $error("allocate did not complete into the response register");

    a_walk_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && stat.can_pop) |=> (state_reg == ST_WALK))
        else $error("retirement walk left before the queue was drained");

endmodule

/* src/fbba_dp.sv */
// Allocator datapath: registers, in-use queue, free stack, response register.
// Depends on fbba_pkg; driven by fbba_ctrl through fbba_cmd_t.
module fbba_dp
    import fbba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [SIZE_W-1:0]     req_size,
    input  fbba_cmd_t             cmd,
    output fbba_stat_t            stat,
    output logic [ID_W-1:0]       rsp_buffer_id,
    output logic [SIZE_W-1:0]     rsp_offset,
    output logic                  rsp_fresh_buffer,
    output logic [CNT_W-1:0]      rsp_retired_count,
    output logic [STATUS_W-1:0]   rsp_status
);

    // Configuration
    logic [SIZE_W-1:0]  backing_size_reg, backing_size_next;
    logic [ALIGN_W-1:0] align_log2_reg, align_log2_next;
    logic [FIF_W-1:0]   fif_reg, fif_next;

    // Allocator state
    logic [FRAME_W-1:0] frame_count_reg, frame_count_next;
    logic [SIZE_W-1:0]  last_fill_reg, last_fill_next;
    logic [ID_W-1:0]    used_head_reg, used_head_next;
    logic [CNT_W-1:0]   used_count_reg, used_count_next;
    logic [CNT_W-1:0]   free_count_reg, free_count_next;
    logic [CNT_W-1:0]   created_count_reg, created_count_next;
    logic [CNT_W-1:0]   freed_reg, freed_next;

    logic [ID_W-1:0]    used_ids_reg    [POOL_BUFFERS];
    logic [FRAME_W-1:0] used_frames_reg [POOL_BUFFERS];
    logic [ID_W-1:0]    free_stack_reg  [POOL_BUFFERS];

    logic [SIZE_W-1:0]  size_reg;

    logic [ID_W-1:0]     rsp_id_reg;
    logic [SIZE_W-1:0]   rsp_offset_reg;
    logic                rsp_fresh_reg;
    logic [CNT_W-1:0]    rsp_freed_reg;
    logic [STATUS_W-1:0] rsp_status_reg;

    // Queue read port and decode
    logic [ID_W-1:0]    newest_slot;
    logic [ID_W-1:0]    tail_slot;
    logic [ID_W-1:0]    rd_slot;
    logic [ID_W-1:0]    rd_id;
    logic [FRAME_W-1:0] rd_frame;
    logic [FRAME_W-1:0] age;
    logic [ID_W-1:0]    free_top;
    logic [SIZE_W:0]    fill_sum;
    logic               oversize;
    logic               fits;
    logic               have_free;
    logic               can_create;
    logic               exhausted;
    logic               push_free;
    logic               take_new;
    logic [ID_W-1:0]    new_id;

    assign newest_slot = used_head_reg + used_count_reg[ID_W-1:0] - ID_W'(1);
    assign tail_slot   = used_head_reg + used_count_reg[ID_W-1:0];
    assign rd_slot     = cmd.walk_sel ? used_head_reg : newest_slot;
    assign rd_id       = used_ids_reg[rd_slot];
    assign rd_frame    = used_frames_reg[rd_slot];
    assign age         = frame_count_reg - rd_frame;
    assign free_top    = free_count_reg[ID_W-1:0] - ID_W'(1);

    assign stat.can_pop = (used_count_reg != '0) &&
                          (age >= FRAME_W'(fif_reg));

    assign fill_sum   = {1'b0, last_fill_reg} + {1'b0, size_reg};
    assign oversize   = size_reg > backing_size_reg;
    assign fits       = (used_count_reg != '0) && (rd_frame == frame_count_reg) &&
                        (fill_sum <= {1'b0, backing_size_reg});
    assign have_free  = (free_count_reg != '0) &&
                        (free_count_reg <= CNT_W'(POOL_BUFFERS));
    assign can_create = created_count_reg < CNT_W'(POOL_BUFFERS);
    assign exhausted  = (used_count_reg >= CNT_W'(POOL_BUFFERS)) ||
                        (!have_free && !can_create);
    assign take_new   = cmd.exec_alloc && !oversize && !fits && !exhausted;
    assign new_id     = have_free ? free_stack_reg[free_top]
                                  : created_count_reg[ID_W-1:0];
    assign push_free  = cmd.pop && (free_count_reg < CNT_W'(POOL_BUFFERS));

    always_comb
    begin
        backing_size_next  = backing_size_reg;
        align_log2_next    = align_log2_reg;
        fif_next           = fif_reg;
        frame_count_next   = frame_count_reg;
        last_fill_next     = last_fill_reg;
        used_head_next     = used_head_reg;
        used_count_next    = used_count_reg;
        free_count_next    = free_count_reg;
        created_count_next = created_count_reg;
        freed_next         = freed_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BACKING_SIZE:     backing_size_next = cfg_data[SIZE_W-1:0];
                CFG_ALIGN_LOG2:       align_log2_next   = cfg_data[ALIGN_W-1:0];
                CFG_FRAMES_IN_FLIGHT: fif_next          = cfg_data[FIF_W-1:0];
                default:              ;
            endcase
        end

        if (cmd.start_frame)
        begin
            frame_count_next = frame_count_reg + FRAME_W'(1);
            freed_next       = '0;
        end

        if (cmd.pop)
        begin
            used_head_next  = used_head_reg + ID_W'(1);
            used_count_next = used_count_reg - CNT_W'(1);
            freed_next      = freed_reg + CNT_W'(1);
            if (push_free)
            begin
                free_count_next = free_count_reg + CNT_W'(1);
            end
        end

        if (cmd.exec_alloc && !oversize)
        begin
            if (fits)
            begin
                last_fill_next = round_fill(fill_sum, align_log2_reg);
            end
            else if (take_new)
            begin
                used_count_next = used_count_reg + CNT_W'(1);
                last_fill_next  = round_fill({1'b0, size_reg}, align_log2_reg);
                if (have_free)
                begin
                    free_count_next = free_count_reg - CNT_W'(1);
                end
                else
                begin
                    created_count_next = created_count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backing_size_reg  <= BACKING_SIZE_RST;
            align_log2_reg    <= ALIGN_LOG2_RST;
            fif_reg           <= FIF_RST;
            frame_count_reg   <= '0;
            last_fill_reg     <= '0;
            used_head_reg     <= '0;
            used_count_reg    <= '0;
            free_count_reg    <= '0;
            created_count_reg <= '0;
            freed_reg         <= '0;
        end
        else
        begin
            backing_size_reg  <= backing_size_next;
            align_log2_reg    <= align_log2_next;
            fif_reg           <= fif_next;
            frame_count_reg   <= frame_count_next;
            last_fill_reg     <= last_fill_next;
            used_head_reg     <= used_head_next;
            used_count_reg    <= used_count_next;
            free_count_reg    <= free_count_next;
            created_count_reg <= created_count_next;
            freed_reg         <= freed_next;
        end
    end

    // Stores and payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            size_reg <= req_size;
        end
        if (take_new)
        begin
            used_ids_reg[tail_slot]    <= new_id;
            used_frames_reg[tail_slot] <= frame_count_reg;
        end
        if (push_free)
        begin
            free_stack_reg[free_count_reg[ID_W-1:0]] <= rd_id;
        end
        if (cmd.exec_alloc)
        begin
            rsp_freed_reg <= '0;
            rsp_fresh_reg <= 1'b0;
            rsp_id_reg    <= '0;
            rsp_offset_reg <= '0;
            if (oversize)
            begin
                rsp_status_reg <= STATUS_OVERSIZE;
            end
            else if (fits)
            begin
                rsp_status_reg <= STATUS_OK;
                rsp_id_reg     <= rd_id;
                rsp_offset_reg <= last_fill_reg;
            end
            else if (exhausted)
            begin
                rsp_status_reg <= STATUS_EXHAUSTED;
            end
            else
            begin
                rsp_status_reg <= STATUS_OK;
                rsp_id_reg     <= new_id;
                rsp_fresh_reg  <= !have_free;
            end
        end
        else if (cmd.load_frame_rsp)
        begin
            rsp_status_reg <= STATUS_OK;
            rsp_id_reg     <= '0;
            rsp_offset_reg <= '0;
            rsp_fresh_reg  <= 1'b0;
            rsp_freed_reg  <= freed_reg;
        end
    end

    assign rsp_buffer_id     = rsp_id_reg;
    assign rsp_offset        = rsp_offset_reg;
    assign rsp_fresh_buffer  = rsp_fresh_reg;
    assign rsp_retired_count = rsp_freed_reg;
    assign rsp_status        = rsp_status_reg;

    // Every id handed out so far is either in use or on the free stack.
    a_ids_conserved: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, used_count_reg} + {1'b0, free_count_reg}) == {1'b0, created_count_reg})
        else $error("buffer ids lost or duplicated between queue and free stack");

    a_created_bound: assert property (@(posedge clk) disable iff (!rst_n)
        created_count_reg <= CNT_W'(POOL_BUFFERS))
        else $error("more buffer ids created than the pool holds");

endmodule

/* src/frame_bump_buffer_allocator_core.sv */
// Frame bump buffer allocator, top level.
// Allocate: taken in ST_IDLE, answered in ST_ALLOC once the response register is free.
// Next frame: ST_WALK retires buffers one per cycle via the queue port, then answers.
// Response register frees the request side: a new request is taken while a result waits.
// Reset (async, active low) clears counters and restores register defaults; no clear pass.
// Depends on fbba_pkg, fbba_if, fbba_ctrl and fbba_dp.
module frame_bump_buffer_allocator_core
    import fbba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fbba_req_if.sink   req,
    fbba_rsp_if.source rsp,
    fbba_cfg_if.sink   cfg
);

    fbba_cmd_t  cmd;
    fbba_stat_t stat;

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    fbba_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.command),
        .req_ready   (req.ready),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    fbba_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg.valid),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .req_size          (req.size),
        .cmd               (cmd),
        .stat              (stat),
        .rsp_buffer_id     (rsp.buffer_id),
        .rsp_offset        (rsp.offset),
        .rsp_fresh_buffer  (rsp.fresh_buffer),
        .rsp_retired_count (rsp.retired_count),
        .rsp_status        (rsp.status)
    );

endmodule
